// File: rtl/gwb_pkg.sv
package gwb_pkg;

  localparam int MAX_COLS = 32;
  localparam int MAX_ROWS = 32;

  localparam int FUNC_W = 2;
  localparam int FLD_W  = 6;
  localparam int DIM_W  = 6;
  localparam int Q_W    = 16;
  localparam int POS_W  = 24;
  localparam int IDX_W  = 3;
  localparam int CFG_DW = 16;

  // coordinates in Q.9, wide enough for any centre, box edge or difference
  localparam int CW = POS_W + 3;

  localparam int HROWS  = MAX_ROWS + 1;
  localparam int HCOLS  = MAX_COLS;
  localparam int VROWS  = MAX_ROWS;
  localparam int VCOLS  = MAX_COLS + 1;
  localparam int HROW_W = $clog2(HROWS);
  localparam int HCOL_W = $clog2(HCOLS);
  localparam int VROW_W = $clog2(VROWS);
  localparam int VCOL_W = $clog2(VCOLS);
  localparam int CNT_W  = $clog2((MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 1);
  localparam int PROD_W = DIM_W + Q_W;

  localparam logic [FUNC_W-1:0] FN_WR_H  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_WR_V  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  localparam logic [IDX_W-1:0] REG_MAZE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAZE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_CELL_SIZE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_HALF_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HALF_DEPTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MARGIN      = 3'd5;
  localparam logic [IDX_W-1:0] REG_BORDER_ONLY = 3'd6;

  localparam logic [DIM_W-1:0] RST_MAZE_WIDTH  = 6'd8;
  localparam logic [DIM_W-1:0] RST_MAZE_HEIGHT = 6'd8;
  localparam logic [Q_W-1:0]   RST_CELL_SIZE   = 16'd512;
  localparam logic [Q_W-1:0]   RST_HALF_WIDTH  = 16'd128;
  localparam logic [Q_W-1:0]   RST_HALF_DEPTH  = 16'd128;
  localparam logic [Q_W-1:0]   RST_MARGIN      = 16'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [DIM_W-1:0] maze_width;
    logic [DIM_W-1:0] maze_height;
    logic [Q_W-1:0]   cell_size;
    logic [Q_W-1:0]   half_width;
    logic [Q_W-1:0]   half_depth;
    logic [Q_W-1:0]   margin;
    logic             border_only;
  } cfg_t;

  typedef struct packed {
    logic clr_step;
    logic wr_h;
    logic wr_v;
    logic load_query;
    logic start_pass;
    logic pass_sel;
    logic rd_row;
    logic start_row;
    logic step_col;
    logic next_row;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic col_last;
    logic row_last;
    logic pass_v;
    logic hit;
  } sts_t;

  function automatic coord_t sx_pos(input logic signed [POS_W-1:0] v);
    return coord_t'(v);
  endfunction

  function automatic coord_t zx_q(input logic [Q_W-1:0] v);
    return coord_t'(v);
  endfunction

endpackage

// File: rtl/gwb_if.sv
interface gwb_item_if;
  import gwb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [FLD_W-1:0]        row;
  logic [FLD_W-1:0]        col;
  logic                    wall_present;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, func, row, col, wall_present, pos_x, pos_z, input ready);
  modport sink (input valid, func, row, col, wall_present, pos_x, pos_z, output ready);
endinterface

interface gwb_result_if;
  logic valid;
  logic ready;
  logic collides;

  modport source (output valid, collides, input ready);
  modport sink (input valid, collides, output ready);
endinterface

// File: rtl/gwb_cfg.sv
module gwb_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [gwb_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gwb_pkg::CFG_DW-1:0] cfg_wdata,
  output gwb_pkg::cfg_t              cfg
);
  import gwb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.maze_width  <= RST_MAZE_WIDTH;
      cfg.maze_height <= RST_MAZE_HEIGHT;
      cfg.cell_size   <= RST_CELL_SIZE;
      cfg.half_width  <= RST_HALF_WIDTH;
      cfg.half_depth  <= RST_HALF_DEPTH;
      cfg.margin      <= RST_MARGIN;
      cfg.border_only <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAZE_WIDTH:  cfg.maze_width  <= cfg_wdata[DIM_W-1:0];
        REG_MAZE_HEIGHT: cfg.maze_height <= cfg_wdata[DIM_W-1:0];
        REG_CELL_SIZE:   cfg.cell_size   <= cfg_wdata[Q_W-1:0];
        REG_HALF_WIDTH:  cfg.half_width  <= cfg_wdata[Q_W-1:0];
        REG_HALF_DEPTH:  cfg.half_depth  <= cfg_wdata[Q_W-1:0];
        REG_MARGIN:      cfg.margin      <= cfg_wdata[Q_W-1:0];
        REG_BORDER_ONLY: cfg.border_only <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/gwb_ctrl.sv
module gwb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic [gwb_pkg::FUNC_W-1:0] item_func,
  output logic                       item_ready,
  input  logic                       result_ready,
  output logic                       result_valid,
  input  gwb_pkg::sts_t              sts,
  output gwb_pkg::cmd_t              cmd
);
  import gwb_pkg::*;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_ROWRD = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          unique case (item_func)
            FN_WR_H: cmd.wr_h = 1'b1;
            FN_WR_V: cmd.wr_v = 1'b1;
            FN_QUERY: begin
              cmd.load_query = 1'b1;
              state_next     = S_SETUP;
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        cmd.start_pass = 1'b1;
        cmd.pass_sel   = 1'b0;
        state_next     = S_ROWRD;
      end
      S_ROWRD: begin
        cmd.rd_row    = 1'b1;
        cmd.start_row = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_next = S_DONE;
        end else if (!sts.col_last) begin
          cmd.step_col = 1'b1;
        end else if (!sts.row_last) begin
          cmd.next_row = 1'b1;
          state_next   = S_ROWRD;
        end else if (!sts.pass_v) begin
          // horizontal walls done, go on with the vertical ones
          cmd.start_pass = 1'b1;
          cmd.pass_sel   = 1'b1;
          state_next     = S_ROWRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/gwb_dp.sv
module gwb_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  gwb_pkg::cfg_t                   cfg,
  input  gwb_pkg::cmd_t                   cmd,
  input  logic [gwb_pkg::FLD_W-1:0]       row,
  input  logic [gwb_pkg::FLD_W-1:0]       col,
  input  logic                            wall_present,
  input  logic signed [gwb_pkg::POS_W-1:0] pos_x,
  input  logic signed [gwb_pkg::POS_W-1:0] pos_z,
  output gwb_pkg::sts_t                   sts,
  output logic                            collides
);
  import gwb_pkg::*;

  logic [HCOLS-1:0] hmem [HROWS];
  logic [VCOLS-1:0] vmem [VROWS];
  logic [HCOLS-1:0] hrd;
  logic [VCOLS-1:0] vrd;

  logic [DIM_W-1:0] w_sat;
  logic [DIM_W-1:0] h_sat;
  coord_t cs;
  coord_t cs2;

  coord_t px9, pz9, xmin9, xmax9, zmin9, zmax9, dlim_x, dlim_z;
  coord_t mw, mh;
  coord_t racc, cacc;
  logic [PROD_W-1:0] mw_prod, mh_prod;

  logic             pass_v;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic             found;

  logic              hwe, vwe;
  logic [HROW_W-1:0] haddr;
  logic [VROW_W-1:0] vaddr;
  logic [HCOLS-1:0]  hmask, hdata;
  logic [VCOLS-1:0]  vmask, vdata;

  logic   bitv, slot_ok, border_ok, span_ok, dist_ok;
  coord_t span_c, smin, smax, dpos, dist_c, dlim, diff;

  assign w_sat = (cfg.maze_width > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg.maze_width;
  assign h_sat = (cfg.maze_height > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg.maze_height;
  assign cs    = zx_q(cfg.cell_size);
  assign cs2   = cs <<< 1;

  assign mw_prod = {{Q_W{1'b0}}, w_sat} * {{DIM_W{1'b0}}, cfg.cell_size};
  assign mh_prod = {{Q_W{1'b0}}, h_sat} * {{DIM_W{1'b0}}, cfg.cell_size};

  // wall bit writes; the clearing pass writes whole rows of zero
  always_comb begin
    hwe   = cmd.clr_step ||
            (cmd.wr_h && row <= FLD_W'(MAX_ROWS) && col < FLD_W'(MAX_COLS));
    vwe   = (cmd.clr_step && i < CNT_W'(MAX_ROWS)) ||
            (cmd.wr_v && row < FLD_W'(MAX_ROWS) && col <= FLD_W'(MAX_COLS));
    haddr = cmd.clr_step ? i[HROW_W-1:0] : row[HROW_W-1:0];
    vaddr = cmd.clr_step ? i[VROW_W-1:0] : row[VROW_W-1:0];
    hmask = cmd.clr_step ? '1 : ({{(HCOLS-1){1'b0}}, 1'b1} << col[HCOL_W-1:0]);
    vmask = cmd.clr_step ? '1 : ({{(VCOLS-1){1'b0}}, 1'b1} << col[VCOL_W-1:0]);
    hdata = cmd.clr_step ? '0 : {HCOLS{wall_present}};
    vdata = cmd.clr_step ? '0 : {VCOLS{wall_present}};
  end

  always_ff @(posedge clk) begin
    if (hwe) begin
      for (int b = 0; b < HCOLS; b++) begin
        if (hmask[b]) hmem[haddr][b] <= hdata[b];
      end
    end
    if (cmd.rd_row) hrd <= hmem[i[HROW_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      for (int b = 0; b < VCOLS; b++) begin
        if (vmask[b]) vmem[vaddr][b] <= vdata[b];
      end
    end
    // a vertical pass reads one row past the end; that slot is masked below
    if (cmd.rd_row) vrd <= vmem[i[VROW_W-1:0]];
  end

  // query bounds in Q.9
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      px9    <= sx_pos(pos_x) <<< 1;
      pz9    <= sx_pos(pos_z) <<< 1;
      xmin9  <= (sx_pos(pos_x) - zx_q(cfg.half_width)) <<< 1;
      xmax9  <= (sx_pos(pos_x) + zx_q(cfg.half_width)) <<< 1;
      zmin9  <= (sx_pos(pos_z) - zx_q(cfg.half_depth)) <<< 1;
      zmax9  <= (sx_pos(pos_z) + zx_q(cfg.half_depth)) <<< 1;
      dlim_x <= (zx_q(cfg.half_width) + zx_q(cfg.margin)) <<< 1;
      dlim_z <= (zx_q(cfg.half_depth) + zx_q(cfg.margin)) <<< 1;
      mw     <= {{(CW-PROD_W){1'b0}}, mw_prod};
      mh     <= {{(CW-PROD_W){1'b0}}, mh_prod};
    end
  end

  // racc follows the row (z) centre, cacc the column (x) centre
  always_ff @(posedge clk) begin
    if (rst) begin
      i        <= '0;
      j        <= '0;
      pass_v   <= 1'b0;
      found    <= 1'b0;
      collides <= 1'b0;
    end else begin
      if (cmd.clr_step) i <= i + CNT_W'(1);
      if (cmd.start_pass) begin
        pass_v <= cmd.pass_sel;
        i      <= '0;
        racc   <= cmd.pass_sel ? (cs - mh) : -mh;
      end
      if (cmd.next_row) begin
        i    <= i + CNT_W'(1);
        racc <= racc + cs2;
      end
      if (cmd.start_row) begin
        j    <= '0;
        cacc <= pass_v ? -mw : (cs - mw);
      end
      if (cmd.step_col) begin
        j    <= j + CNT_W'(1);
        cacc <= cacc + cs2;
      end
      if (cmd.load_query) found <= 1'b0;
      else if (cmd.scan && sts.hit) found <= 1'b1;
      if (cmd.emit) collides <= found;
    end
  end

  // one wall slot per cycle while a row scans; the span and distance axes swap between passes
  always_comb begin
    bitv      = pass_v ? vrd[j[VCOL_W-1:0]] : hrd[j[HCOL_W-1:0]];
    slot_ok   = pass_v ? (i != CNT_W'(h_sat)) : (j != CNT_W'(w_sat));
    border_ok = !cfg.border_only ||
                (pass_v ? (j == '0 || j == CNT_W'(w_sat)) : (i == '0 || i == CNT_W'(h_sat)));
    span_c    = pass_v ? racc : cacc;
    smin      = pass_v ? zmin9 : xmin9;
    smax      = pass_v ? zmax9 : xmax9;
    dist_c    = pass_v ? cacc : racc;
    dpos      = pass_v ? px9 : pz9;
    dlim      = pass_v ? dlim_x : dlim_z;
    diff      = dpos - dist_c;
    span_ok   = (smin <= span_c + cs) && (smax >= span_c - cs);
    dist_ok   = (diff < dlim) && (diff > -dlim);
  end

  assign sts.hit      = bitv && slot_ok && border_ok && span_ok && dist_ok;
  assign sts.col_last = (j == CNT_W'(w_sat));
  assign sts.row_last = (i == CNT_W'(h_sat));
  assign sts.clr_last = (i == CNT_W'(MAX_ROWS));
  assign sts.pass_v   = pass_v;

endmodule

// File: rtl/grid_wall_box_collision_unit.sv
// channel  | dir | payload                                        | handshake
// item     | in  | func, row, col, wall_present, pos_x, pos_z     | valid / ready
// result   | out | collides                                       | valid / ready
// cfg      | in  | cfg_index, cfg_wdata                           | cfg_wr_en
//
// wall writes and unused codes leave the block idle, so they are taken back to back
// a query loads its bounds, sets up, scans a horizontal and then a vertical pass of H + 1 rows each
// (H, W capped at 32) and ends early on a hit: each row is read, then its wall slots are tested one per cycle
// after reset a clearing pass zeroes both wall memories row by row; no requests then
// the result sits in an output register, so a stalled result holds the block only
// once the next query finishes
module grid_wall_box_collision_unit (
  input  logic                       clk,
  input  logic                       rst,
  gwb_item_if.sink                   item,
  gwb_result_if.source               result,
  input  logic                       cfg_wr_en,
  input  logic [gwb_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gwb_pkg::CFG_DW-1:0] cfg_wdata
);
  import gwb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  gwb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gwb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_func    (item.func),
    .item_ready   (item.ready),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  gwb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .row          (item.row),
    .col          (item.col),
    .wall_present (item.wall_present),
    .pos_x        (item.pos_x),
    .pos_z        (item.pos_z),
    .sts          (sts),
    .collides     (result.collides)
  );

endmodule

// File: rtl/gwb_chk.sv
module gwb_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic [gwb_pkg::FUNC_W-1:0] item_func,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic                       result_collides
);
  import gwb_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_collides))
    else $error("stalled result changed");

  // reset starts the clearing pass: nothing is taken and nothing shown
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && !item_ready)
    else $error("block not held off after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_func == FN_QUERY |=> !item_ready)
    else $error("request taken during a scan");

  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_func != FN_QUERY |=> item_ready)
    else $error("wall write did not finish in one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> item_ready)
    else $error("result shown but block not idle");

endmodule

bind grid_wall_box_collision_unit gwb_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .item_func       (item.func),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_collides (result.collides)
);

// File: bench/wall_hit_checker.sv
`timescale 1ns / 1ps
module wall_hit_checker (
  input  logic                       clk,
  input  logic                       rst,
  gwb_item_if                        req,
  gwb_result_if                      rsp,
  input  logic                       cfg_wr_en,
  input  logic [gwb_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gwb_pkg::CFG_DW-1:0] cfg_wdata,
  output int                         errors,
  output int                         outstanding
);
  import gwb_pkg::*;

  cfg_t cfg;
  bit   hwall [0:HROWS-1][0:HCOLS-1];
  bit   vwall [0:VROWS-1][0:VCOLS-1];
  bit   exp_collides [$];
  int   fails = 0;
  int   seen = 0;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  // all distances in Q.9 so wall centers at half cells stay exact
  function automatic bit box_hits_wall(input longint px, input longint pz);
    longint w, h, cs, cx, cz, d;
    longint xlo, xhi, zlo, zhi, lim_x, lim_z;
    w = (cfg.maze_width > MAX_COLS) ? longint'(MAX_COLS) : longint'(cfg.maze_width);
    h = (cfg.maze_height > MAX_ROWS) ? longint'(MAX_ROWS) : longint'(cfg.maze_height);
    cs = longint'(cfg.cell_size);
    xlo = 2 * (px - longint'(cfg.half_width));
    xhi = 2 * (px + longint'(cfg.half_width));
    zlo = 2 * (pz - longint'(cfg.half_depth));
    zhi = 2 * (pz + longint'(cfg.half_depth));
    lim_x = 2 * (longint'(cfg.half_width) + longint'(cfg.margin));
    lim_z = 2 * (longint'(cfg.half_depth) + longint'(cfg.margin));
    for (longint i = 0; i <= h; i++) begin
      for (longint j = 0; j < w; j++) begin
        if (!hwall[i][j]) continue;
        if (cfg.border_only && i != 0 && i != h) continue;
        cx = (2 * j - w + 1) * cs;
        cz = (2 * i - h) * cs;
        d = 2 * pz - cz;
        if (d < 0) d = -d;
        if (xlo <= cx + cs && xhi >= cx - cs && d < lim_z) return 1'b1;
      end
    end
    for (longint i = 0; i < h; i++) begin
      for (longint j = 0; j <= w; j++) begin
        if (!vwall[i][j]) continue;
        if (cfg.border_only && j != 0 && j != w) continue;
        cx = (2 * j - w) * cs;
        cz = (2 * i - h + 1) * cs;
        d = 2 * px - cx;
        if (d < 0) d = -d;
        if (zlo <= cz + cs && zhi >= cz - cs && d < lim_x) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : track
    bit want;
    if (rst) begin
      cfg = '{maze_width: RST_MAZE_WIDTH, maze_height: RST_MAZE_HEIGHT,
              cell_size: RST_CELL_SIZE, half_width: RST_HALF_WIDTH,
              half_depth: RST_HALF_DEPTH, margin: RST_MARGIN, border_only: 1'b0};
      foreach (hwall[r, c]) hwall[r][c] = 1'b0;
      foreach (vwall[r, c]) vwall[r][c] = 1'b0;
      exp_collides.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen++;
        if (exp_collides.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("result %0d: collides=%b with no query outstanding", seen, rsp.collides);
        end else begin
          want = exp_collides.pop_front();
          if (rsp.collides !== want) begin
            fails++;
            if (fails <= 10)
              $display("result %0d: collides expected %b, got %b", seen, want, rsp.collides);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAZE_WIDTH:  cfg.maze_width = cfg_wdata[DIM_W-1:0];
          REG_MAZE_HEIGHT: cfg.maze_height = cfg_wdata[DIM_W-1:0];
          REG_CELL_SIZE:   cfg.cell_size = cfg_wdata[Q_W-1:0];
          REG_HALF_WIDTH:  cfg.half_width = cfg_wdata[Q_W-1:0];
          REG_HALF_DEPTH:  cfg.half_depth = cfg_wdata[Q_W-1:0];
          REG_MARGIN:      cfg.margin = cfg_wdata[Q_W-1:0];
          REG_BORDER_ONLY: cfg.border_only = cfg_wdata[0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.func)
          FN_WR_H: begin
            if (req.row <= MAX_ROWS && req.col < MAX_COLS)
              hwall[req.row][req.col] = req.wall_present;
          end
          FN_WR_V: begin
            if (req.row < MAX_ROWS && req.col <= MAX_COLS)
              vwall[req.row][req.col] = req.wall_present;
          end
          FN_QUERY: exp_collides.push_back(box_hits_wall(longint'(req.pos_x),
                                                         longint'(req.pos_z)));
          default: ;
        endcase
      end
    end
    errors <= fails;
    outstanding <= exp_collides.size();
  end

endmodule

// File: bench/tb_grid_wall_box_collision_unit.sv
`timescale 1ns / 1ps
module tb_grid_wall_box_collision_unit;
  import gwb_pkg::*;

  localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
  localparam int HOLD_CYCLES   = 1500;
  localparam int STALL_LIMIT   = 12000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_LIGHT, DRAIN_HEAVY} drain_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  int                errors;
  int                outstanding;
  int                idle_cycles = 0;
  int                burst_left = 1;
  bit                hold_go = 1'b0;

  // stimulus-side copy of the settings, only used to aim queries and wall writes at the grid
  longint cur_cs = longint'(RST_CELL_SIZE);
  longint cur_hw = longint'(RST_HALF_WIDTH);
  longint cur_hd = longint'(RST_HALF_DEPTH);
  longint cur_mg = longint'(RST_MARGIN);
  longint scan_w = longint'(RST_MAZE_WIDTH);
  longint scan_h = longint'(RST_MAZE_HEIGHT);

  gwb_item_if   req_if ();
  gwb_result_if rsp_if ();

  always #2 clk = ~clk;

  grid_wall_box_collision_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (req_if),
    .result    (rsp_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  wall_hit_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_if),
    .rsp         (rsp_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: stall patterns in random spans, plus one long hold on request
  initial begin : result_stalls
    drain_mode_t mode;
    int span;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = drain_mode_t'($urandom_range(0, 3));
      span = $urandom_range(1, 40);
      repeat (span) begin
        case (mode)
          DRAIN_FREE:  rsp_if.ready <= 1'b1;
          DRAIN_HALF:  rsp_if.ready <= ($urandom_range(0, 1) == 0);
          DRAIN_LIGHT: rsp_if.ready <= ($urandom_range(0, 7) != 0);
          default:     rsp_if.ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // valid stays high across a burst; the caller follows up in the same step
  task automatic issue(input logic [FUNC_W-1:0] fn, input logic [FLD_W-1:0] r,
                       input logic [FLD_W-1:0] c, input logic wp,
                       input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] z);
    int gap;
    req_if.valid        <= 1'b1;
    req_if.func         <= fn;
    req_if.row          <= r;
    req_if.col          <= c;
    req_if.wall_present <= wp;
    req_if.pos_x        <= x;
    req_if.pos_z        <= z;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_wall(input logic [FUNC_W-1:0] fn, input logic [FLD_W-1:0] r,
                          input logic [FLD_W-1:0] c, input logic wp);
    issue(fn, r, c, wp, '0, '0);
  endtask

  task automatic drain;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                              input logic [CFG_DW-1:0] cs, input logic [CFG_DW-1:0] hw,
                              input logic [CFG_DW-1:0] hd, input logic [CFG_DW-1:0] mg,
                              input logic [CFG_DW-1:0] bo);
    logic [CFG_DW-1:0] vals [0:6];
    vals[REG_MAZE_WIDTH]  = w;
    vals[REG_MAZE_HEIGHT] = h;
    vals[REG_CELL_SIZE]   = cs;
    vals[REG_HALF_WIDTH]  = hw;
    vals[REG_HALF_DEPTH]  = hd;
    vals[REG_MARGIN]      = mg;
    vals[REG_BORDER_ONLY] = bo;
    for (int k = 0; k < 7; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= IDX_W'(k);
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cur_cs = longint'(cs);
    cur_hw = longint'(hw);
    cur_hd = longint'(hd);
    cur_mg = longint'(mg);
    scan_w = (w[DIM_W-1:0] > DIM_W'(MAX_COLS)) ? longint'(MAX_COLS)
                                              : longint'(w[DIM_W-1:0]);
    scan_h = (h[DIM_W-1:0] > DIM_W'(MAX_ROWS)) ? longint'(MAX_ROWS)
                                              : longint'(h[DIM_W-1:0]);
  endtask

  function automatic longint spread(input longint reach);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * reach)));
    return off - reach;
  endfunction

  task automatic random_write;
    logic [FUNC_W-1:0] fn;
    logic [FLD_W-1:0]  r, c;
    fn = $urandom_range(0, 1) ? FN_WR_V : FN_WR_H;
    if ($urandom_range(0, 9) == 0) begin
      r = FLD_W'($urandom);
      c = FLD_W'($urandom);
    end else if (fn == FN_WR_H) begin
      r = FLD_W'($urandom_range(0, 32'(scan_h)));
      c = (scan_w == 0) ? '0 : FLD_W'($urandom_range(0, 32'(scan_w - 1)));
    end else begin
      r = (scan_h == 0) ? '0 : FLD_W'($urandom_range(0, 32'(scan_h - 1)));
      c = FLD_W'($urandom_range(0, 32'(scan_w)));
    end
    issue(fn, r, c, $urandom_range(0, 9) < 6, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic random_query;
    int sel;
    bit horiz;
    longint i, j, cx, cz, px, pz, sgn, nudge;
    logic signed [POS_W-1:0] qx, qz;
    sel = $urandom_range(0, 19);
    if (sel < 13) begin
      horiz = 1'($urandom_range(0, 1));
      if (horiz) begin
        i = longint'($urandom_range(0, 32'(scan_h)));
        j = (scan_w == 0) ? longint'(0) : longint'($urandom_range(0, 32'(scan_w - 1)));
        cx = (2 * j - scan_w + 1) * cur_cs / 2;
        cz = (2 * i - scan_h) * cur_cs / 2;
      end else begin
        i = (scan_h == 0) ? longint'(0) : longint'($urandom_range(0, 32'(scan_h - 1)));
        j = longint'($urandom_range(0, 32'(scan_w)));
        cx = (2 * j - scan_w) * cur_cs / 2;
        cz = (2 * i - scan_h + 1) * cur_cs / 2;
      end
      px = cx + spread(cur_hw + cur_mg + cur_cs / 2 + 2);
      pz = cz + spread(cur_hd + cur_mg + cur_cs / 2 + 2);
      if ($urandom_range(0, 2) == 0) begin
        // right on the strict distance limit, or one step inside it
        sgn = $urandom_range(0, 1) ? longint'(1) : longint'(-1);
        nudge = longint'($urandom_range(0, 1));
        if (horiz) pz = cz + sgn * (cur_hd + cur_mg - nudge);
        else px = cx + sgn * (cur_hw + cur_mg - nudge);
      end
      qx = px[POS_W-1:0];
      qz = pz[POS_W-1:0];
    end else if (sel < 17) begin
      qx = POS_W'($urandom);
      qz = POS_W'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       qx = 24'sh7FFFFF;
        1:       qx = 24'sh800000;
        default: qx = '0;
      endcase
      case ($urandom_range(0, 2))
        0:       qz = 24'sh7FFFFF;
        1:       qz = 24'sh800000;
        default: qz = '0;
      endcase
    end
    issue(FN_QUERY, FLD_W'($urandom), FLD_W'($urandom), 1'($urandom_range(0, 1)), qx, qz);
  endtask

  task automatic run_random(input int count, input bit with_hold);
    int roll;
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == count / 3) hold_go = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 55) random_write();
      else if (roll < 93) random_query();
      else issue(FN_NONE, FLD_W'($urandom), FLD_W'($urandom), 1'($urandom_range(0, 1)),
                 POS_W'($urandom), POS_W'($urandom));
    end
    req_if.valid <= 1'b0;
    drain();
  endtask

  initial begin : stimulus
    req_if.valid        <= 1'b0;
    req_if.func         <= FN_WR_H;
    req_if.row          <= '0;
    req_if.col          <= '0;
    req_if.wall_present <= 1'b0;
    req_if.pos_x        <= '0;
    req_if.pos_z        <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= REG_MAZE_WIDTH;
    cfg_wdata           <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // power-on settings: 8x8 maze, 2.0 cells, 0.5 box, small margin
    issue(FN_QUERY, '0, '0, 1'b0, 0, 0);
    put_wall(FN_WR_H, 0, 0, 1'b1);
    issue(FN_QUERY, '0, '0, 1'b0, -1792, -2048);
    issue(FN_QUERY, '0, '0, 1'b0, -1792, -1917);
    issue(FN_QUERY, '0, '0, 1'b0, -1792, -1918);
    issue(FN_QUERY, '0, '0, 1'b0, -2176, -2048);
    issue(FN_QUERY, '0, '0, 1'b0, -2177, -2048);
    put_wall(FN_WR_V, 3, 8, 1'b1);
    issue(FN_QUERY, '0, '0, 1'b0, 2048, -256);
    put_wall(FN_WR_H, 32, 31, 1'b1);
    put_wall(FN_WR_V, 31, 32, 1'b1);
    // writes just past the store edges are dropped
    put_wall(FN_WR_H, 33, 0, 1'b1);
    put_wall(FN_WR_H, 0, 32, 1'b1);
    put_wall(FN_WR_V, 32, 0, 1'b1);
    put_wall(FN_WR_V, 0, 33, 1'b1);
    issue(FN_NONE, 6'h3F, 6'h3F, 1'b1, 24'sh7FFFFF, 24'sh800000);
    issue(FN_QUERY, '0, '0, 1'b0, 24'sh7FFFFF, 24'sh7FFFFF);
    issue(FN_QUERY, '0, '0, 1'b0, 24'sh800000, 24'sh800000);
    put_wall(FN_WR_H, 0, 0, 1'b0);
    issue(FN_QUERY, '0, '0, 1'b0, -1792, -2048);
    put_wall(FN_WR_H, 4, 3, 1'b1);
    issue(FN_QUERY, '0, '0, 1'b0, -256, 0);
    req_if.valid <= 1'b0;
    drain();

    // border-only: interior wall drops out, border walls still count
    write_config(8, 8, 512, 128, 128, 3, 1);
    issue(FN_QUERY, '0, '0, 1'b0, -256, 0);
    issue(FN_QUERY, '0, '0, 1'b0, 2048, -256);
    put_wall(FN_WR_H, 8, 2, 1'b1);
    issue(FN_QUERY, '0, '0, 1'b0, -768, 2048);
    run_random(30, 1'b0);

    write_config(4, 5, 300, 200, 90, 7, 0);
    run_random(40, 1'b0);
    write_config(0, 0, 256, 16'hFFFF, 16'hFFFF, 0, 0);
    run_random(25, 1'b0);
    // oversized maze saturates to the store size: slow scans, few requests
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 1);
    run_random(20, 1'b0);
    write_config(1, 32, 0, 50, 60, 1, 0);
    run_random(25, 1'b0);
    for (int p = 0; p < 3; p++) begin
      write_config(CFG_DW'($urandom_range(0, 10)), CFG_DW'($urandom_range(0, 10)),
                   CFG_DW'($urandom_range(0, 65535)), CFG_DW'($urandom_range(0, 2000)),
                   CFG_DW'($urandom_range(0, 2000)), CFG_DW'($urandom_range(0, 300)),
                   CFG_DW'($urandom_range(0, 1)));
      run_random(30, p == 0);
    end
    write_config(32, 1, 1, 1, 16'hFFFF, 2, 0);
    run_random(20, 1'b0);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
